>>> rtl/pcp_pkg.sv
// Package for the pinhole camera projection block: default widths,
// operation and status codes, register indexes and reset values.
// No dependencies.
package pcp_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int ENTRY_WIDTH_DEF = 21;
   localparam int REG_W           = 63;
   localparam int ADDR_W          = 2;
   localparam int FRAC_W          = 16;

   typedef enum logic {
      OP_PROJECT     = 1'b0,
      OP_BACKPROJECT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_SINGULAR = 2'd2,
      ST_SAT      = 2'd3
   } status_type;

   localparam logic [ADDR_W-1:0] REG_ROW_TOP    = 2'd0;
   localparam logic [ADDR_W-1:0] REG_ROW_MID    = 2'd1;
   localparam logic [ADDR_W-1:0] REG_ROW_BOTTOM = 2'd2;

   localparam logic [REG_W-1:0] ROW_TOP_RST    = 63'd256;
   localparam logic [REG_W-1:0] ROW_MID_RST    = 63'd536870912;
   localparam logic [REG_W-1:0] ROW_BOTTOM_RST = 63'd1125899906842624;

endpackage

>>> rtl/pinhole_camera_projection_top.sv
// Throughput: one word per cycle while the result is not stalled; the one-bit-per-stage divider chain sets the depth.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits and loads K with 256 times identity.
// A K write is usable by a word accepted in the next cycle.
module pinhole_camera_projection_top
   import pcp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
   localparam int IN_DW  = ((3*COORD_WIDTH+7)/8)*8,
   localparam int OUT_DW = ((2*COORD_WIDTH+7)/8)*8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [IN_DW-1:0]  req_tdata,   // in_x, in_y, in_z
   input  logic              req_tuser,   // operation
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OUT_DW-1:0] rsp_tdata,   // result_x, result_y
   output logic [1:0]        rsp_tuser,   // status
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_addr,
   input  logic [REG_W-1:0]  csr_wdata
);

   localparam int CW  = COORD_WIDTH;
   localparam int EW  = ENTRY_WIDTH;
   localparam int CFW = 2*EW+1;
   localparam int OW  = CW+2;
   localparam int PW  = CFW+OW;
   localparam int AW  = PW+2;
   localparam int MW  = AW;
   localparam int DW  = EW+CFW+2;
   localparam int QN  = CW+2;
   localparam int NW  = MW+FRAC_W+1;
   localparam int HW  = NW-QN;
   localparam int LH  = OW/2;
   localparam int PLW = CFW+LH+1;
   localparam int PHW = CFW+OW-LH;

   typedef struct packed {
      logic          neg_x;
      logic          neg_y;
      logic [1:0]    stat;
      logic          ovf_x;
      logic          ovf_y;
      logic [MW-1:0] den;
      logic [MW-1:0] rem_x;
      logic [MW-1:0] rem_y;
      logic [QN-1:0] num_x;
      logic [QN-1:0] num_y;
      logic [QN-1:0] quo_x;
      logic [QN-1:0] quo_y;
   } dv_type;

   logic                 adv;
   logic [REG_W-1:0]     row_ff [3];
   logic signed [EW-1:0] kk [3][3];
   logic signed [CFW-1:0] cof_ff [3][3];
   logic signed [DW-1:0] det_ff;

   logic                 p0_vld_ff, p1_vld_ff, p2_vld_ff, p3_vld_ff;
   logic                 p0_op_ff, p1_op_ff;
   logic signed [OW-1:0] p0_c_ff [3];
   logic signed [PLW-1:0] plo_ff [3][3];
   logic signed [PHW-1:0] phi_ff [3][3];
   logic signed [AW-1:0] acc_ff [3];
   logic [1:0]           p2_stat_ff, p3_stat_ff;
   logic                 p3_negx_ff, p3_negy_ff;
   logic [MW-1:0]        mag_ff [3];

   logic                 dv_vld_ff [QN+1];
   dv_type               dv_ff [QN+1];

   logic                 rsp_vld_ff;
   logic [CW-1:0]        rx_ff, ry_ff;
   logic [1:0]           rst_ff;

   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= ROW_TOP_RST;
         row_ff[1] <= ROW_MID_RST;
         row_ff[2] <= ROW_BOTTOM_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_ROW_TOP:    row_ff[0] <= csr_wdata;
            REG_ROW_MID:    row_ff[1] <= csr_wdata;
            REG_ROW_BOTTOM: row_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         assign kk[r][j] = row_ff[r][j*EW +: EW];
      end
   end

   always_ff @(posedge clock) begin
      cof_ff[0][0] <= CFW'(kk[1][1]) * CFW'(kk[2][2]) - CFW'(kk[1][2]) * CFW'(kk[2][1]);
      cof_ff[0][1] <= CFW'(kk[0][2]) * CFW'(kk[2][1]) - CFW'(kk[0][1]) * CFW'(kk[2][2]);
      cof_ff[0][2] <= CFW'(kk[0][1]) * CFW'(kk[1][2]) - CFW'(kk[0][2]) * CFW'(kk[1][1]);
      cof_ff[1][0] <= CFW'(kk[1][2]) * CFW'(kk[2][0]) - CFW'(kk[1][0]) * CFW'(kk[2][2]);
      cof_ff[1][1] <= CFW'(kk[0][0]) * CFW'(kk[2][2]) - CFW'(kk[0][2]) * CFW'(kk[2][0]);
      cof_ff[1][2] <= CFW'(kk[0][2]) * CFW'(kk[1][0]) - CFW'(kk[0][0]) * CFW'(kk[1][2]);
      cof_ff[2][0] <= CFW'(kk[1][0]) * CFW'(kk[2][1]) - CFW'(kk[1][1]) * CFW'(kk[2][0]);
      cof_ff[2][1] <= CFW'(kk[0][1]) * CFW'(kk[2][0]) - CFW'(kk[0][0]) * CFW'(kk[2][1]);
      cof_ff[2][2] <= CFW'(kk[0][0]) * CFW'(kk[1][1]) - CFW'(kk[0][1]) * CFW'(kk[1][0]);
      det_ff <= DW'(kk[0][0]) * DW'(cof_ff[0][0]) + DW'(kk[0][1]) * DW'(cof_ff[1][0])
              + DW'(kk[0][2]) * DW'(cof_ff[2][0]);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_vld_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int s = 0; s <= QN; s++) dv_vld_ff[s] <= 1'b0;
      end else if (adv) begin
         p0_vld_ff    <= req_tvalid;
         p1_vld_ff    <= p0_vld_ff;
         p2_vld_ff    <= p1_vld_ff;
         p3_vld_ff    <= p2_vld_ff;
         dv_vld_ff[0] <= p3_vld_ff;
         for (int s = 1; s <= QN; s++) dv_vld_ff[s] <= dv_vld_ff[s-1];
         rsp_vld_ff   <= dv_vld_ff[QN];
      end
   end

   // input, split partial products, sums
   logic signed [OW-1:0]  c2_in;
   logic signed [OW-1:0]  cv_in [3];
   logic signed [CFW-1:0] mul_in [3][3];
   logic signed [AW-1:0]  acc_in [3];
   assign c2_in = (p0_op_ff == OP_BACKPROJECT) ? (OW'(1) <<< FRAC_W) : p0_c_ff[2];
   assign cv_in[0] = p0_c_ff[0];
   assign cv_in[1] = p0_c_ff[1];
   assign cv_in[2] = c2_in;

   for (genvar r = 0; r < 3; r++) begin : g_acc
      for (genvar j = 0; j < 3; j++) begin : g_mul
         assign mul_in[r][j] = (p0_op_ff == OP_BACKPROJECT) ? cof_ff[r][j]
                                                             : CFW'(kk[r][j]);
      end
      assign acc_in[r] = (AW'(phi_ff[r][0]) <<< LH) + (AW'(phi_ff[r][1]) <<< LH)
                       + (AW'(phi_ff[r][2]) <<< LH) + AW'(plo_ff[r][0])
                       + AW'(plo_ff[r][1]) + AW'(plo_ff[r][2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_op_ff   <= req_tuser;
         p0_c_ff[0] <= OW'($signed(req_tdata[0*CW +: CW]));
         p0_c_ff[1] <= OW'($signed(req_tdata[1*CW +: CW]));
         p0_c_ff[2] <= OW'($signed(req_tdata[2*CW +: CW]));
         p1_op_ff   <= p0_op_ff;
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               plo_ff[r][j] <= PLW'(mul_in[r][j])
                             * PLW'($signed({1'b0, cv_in[j][LH-1:0]}));
               phi_ff[r][j] <= PHW'(mul_in[r][j]) * PHW'($signed(cv_in[j][OW-1:LH]));
            end
         end
         for (int r = 0; r < 3; r++) acc_ff[r] <= acc_in[r];
         p2_stat_ff <= (p1_op_ff == OP_BACKPROJECT && det_ff == '0) ? ST_SINGULAR : ST_OK;
         p3_negx_ff <= acc_ff[0][AW-1] ^ acc_ff[2][AW-1];
         p3_negy_ff <= acc_ff[1][AW-1] ^ acc_ff[2][AW-1];
         for (int r = 0; r < 3; r++)
            mag_ff[r] <= acc_ff[r][AW-1] ? MW'(-acc_ff[r]) : MW'(acc_ff[r]);
         p3_stat_ff <= (p2_stat_ff == ST_OK && acc_ff[2] == '0) ? ST_ZERO_DEN : p2_stat_ff;
      end
   end

   // divider entry: overflow check on the high part
   logic [NW-1:0] nx_in, ny_in;
   logic [MW-1:0] hx_in, hy_in;
   assign nx_in = {mag_ff[0], {(FRAC_W+1){1'b0}}};
   assign ny_in = {mag_ff[1], {(FRAC_W+1){1'b0}}};
   assign hx_in = {{(MW-HW){1'b0}}, nx_in[NW-1:QN]};
   assign hy_in = {{(MW-HW){1'b0}}, ny_in[NW-1:QN]};

   function automatic dv_type div_step(input dv_type a);
      dv_type     b;
      logic [MW:0] tx, ty;
      b = a;
      tx = {a.rem_x, a.num_x[QN-1]};
      ty = {a.rem_y, a.num_y[QN-1]};
      b.num_x = a.num_x << 1;
      b.num_y = a.num_y << 1;
      if (tx >= {1'b0, a.den}) begin
         b.rem_x = MW'(tx - {1'b0, a.den});
         b.quo_x = {a.quo_x[QN-2:0], 1'b1};
      end else begin
         b.rem_x = tx[MW-1:0];
         b.quo_x = {a.quo_x[QN-2:0], 1'b0};
      end
      if (ty >= {1'b0, a.den}) begin
         b.rem_y = MW'(ty - {1'b0, a.den});
         b.quo_y = {a.quo_y[QN-2:0], 1'b1};
      end else begin
         b.rem_y = ty[MW-1:0];
         b.quo_y = {a.quo_y[QN-2:0], 1'b0};
      end
      return b;
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0].neg_x <= p3_negx_ff;
         dv_ff[0].neg_y <= p3_negy_ff;
         dv_ff[0].stat  <= p3_stat_ff;
         dv_ff[0].ovf_x <= hx_in >= mag_ff[2];
         dv_ff[0].ovf_y <= hy_in >= mag_ff[2];
         dv_ff[0].den   <= mag_ff[2];
         dv_ff[0].rem_x <= hx_in;
         dv_ff[0].rem_y <= hy_in;
         dv_ff[0].num_x <= nx_in[QN-1:0];
         dv_ff[0].num_y <= ny_in[QN-1:0];
         dv_ff[0].quo_x <= '0;
         dv_ff[0].quo_y <= '0;
      end
   end

   for (genvar s = 1; s <= QN; s++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv) dv_ff[s] <= div_step(dv_ff[s-1]);
      end
   end

   // round, saturate, sign
   logic [QN:0]   qx_full, qy_full;
   logic [QN-1:0] qx_in, qy_in, limx_in, limy_in, mx_in, my_in;
   logic          satx_in, saty_in;
   dv_type        dl;
   assign dl      = dv_ff[QN];
   assign qx_full = (QN+1)'(dl.quo_x) + (QN+1)'(1);
   assign qy_full = (QN+1)'(dl.quo_y) + (QN+1)'(1);
   assign qx_in   = qx_full[QN:1];
   assign qy_in   = qy_full[QN:1];
   assign limx_in = (QN'(1) << (CW-1)) - QN'(!dl.neg_x);
   assign limy_in = (QN'(1) << (CW-1)) - QN'(!dl.neg_y);
   assign satx_in = dl.ovf_x || (qx_in > limx_in);
   assign saty_in = dl.ovf_y || (qy_in > limy_in);
   assign mx_in   = satx_in ? limx_in : qx_in;
   assign my_in   = saty_in ? limy_in : qy_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (dl.stat != ST_OK) begin
            rx_ff  <= '0;
            ry_ff  <= '0;
            rst_ff <= dl.stat;
         end else begin
            rx_ff  <= dl.neg_x ? CW'(-mx_in) : CW'(mx_in);
            ry_ff  <= dl.neg_y ? CW'(-my_in) : CW'(my_in);
            rst_ff <= (satx_in || saty_in) ? ST_SAT : ST_OK;
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = OUT_DW'({ry_ff, rx_ff});
   assign rsp_tuser  = rst_ff;

`ifndef SYNTHESIS
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> p0_vld_ff)
      else $error("accepted word not captured");
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_SINGULAR) |-> (rx_ff == '0 && ry_ff == '0))
      else $error("singular result not zero");
   a_zden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_ZERO_DEN) |-> (rx_ff == '0 && ry_ff == '0))
      else $error("zero denominator result not zero");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dv_vld_ff[QN]) && $stable(p3_vld_ff))
      else $error("pipeline moved during stall");
`endif

endmodule
